[sv/sspq_pkg.sv]
package sspq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int PRIO_WIDTH_DEFAULT = 16;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // operation broadcast to every cell of the row
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

[sv/sspq_cell.sv]
module sspq_cell import sspq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH = PRIO_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic                         occupied,
   input  logic [DATA_WIDTH-1:0]        new_value,
   input  logic signed [PRIO_WIDTH-1:0] new_prio,
   input  logic                         left_after,
   input  logic [DATA_WIDTH-1:0]        left_value,
   input  logic signed [PRIO_WIDTH-1:0] left_prio,
   input  logic [DATA_WIDTH-1:0]        right_value,
   input  logic signed [PRIO_WIDTH-1:0] right_prio,
   output logic [DATA_WIDTH-1:0]        value,
   output logic signed [PRIO_WIDTH-1:0] prio,
   output logic                         after
);

   logic [DATA_WIDTH-1:0]        value_ff;
   logic [DATA_WIDTH-1:0]        value_in;
   logic signed [PRIO_WIDTH-1:0] prio_ff;
   logic signed [PRIO_WIDTH-1:0] prio_in;

   // new item goes behind every held entry with equal or lower priority
   assign after = occupied && (prio_ff <= new_prio);

   always_comb begin
      value_in = value_ff;
      prio_in = prio_ff;
      if (ctl.insert) begin
         if (!after) begin
            if (left_after) begin
               value_in = new_value;
               prio_in = new_prio;
            end else begin
               value_in = left_value;
               prio_in = left_prio;
            end
         end
      end else if (ctl.remove) begin
         value_in = right_value;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff <= prio_in;
   end

   assign value = value_ff;
   assign prio = prio_ff;

endmodule

[sv/stable_sorted_priority_queue_top.sv]
// channel | handshake            | fields                                               | dir
// req     | req_valid, req_ready | mode, item_value, item_priority                      | in
// rsp     | rsp_valid, rsp_ready | status, removed_value, head_value, entry_count, empty_flag | out
//
// one item per cycle unless a result is stalled: every cell of the row updates in the same cycle,
// comparing its priority against the new one and shifting toward its neighbor
// the result is registered and shows in the cycle after the item is accepted
// reset empties the queue at once; no clearing pass is needed
// a stalled result holds back the next item only while rsp_ready is low
module stable_sorted_priority_queue_top import sspq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH = PRIO_WIDTH_DEFAULT,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [DATA_WIDTH-1:0]        req_item_value,
   input  logic signed [PRIO_WIDTH-1:0] req_item_priority,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [DATA_WIDTH-1:0]        rsp_removed_value,
   output logic [DATA_WIDTH-1:0]        rsp_head_value,
   output logic [CountWidth-1:0]        rsp_entry_count,
   output logic                         rsp_empty_flag
);

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;
   logic [DATA_WIDTH-1:0] removed_ff;
   logic [DATA_WIDTH-1:0] removed_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic req_fire;
   logic full;
   logic empty;
   cell_ctl_type ctl;

   logic [DATA_WIDTH-1:0]        cell_value [DEPTH];
   logic signed [PRIO_WIDTH-1:0] cell_prio [DEPTH];
   logic [DEPTH-1:0]             cell_after;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign full = (count_ff == CountWidth'(DEPTH));
   assign empty = (count_ff == '0);

   assign ctl.insert = req_fire && (req_mode == MODE_INSERT) && !full;
   assign ctl.remove = req_fire && (req_mode == MODE_REMOVE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         occupied;
      logic                         left_after;
      logic [DATA_WIDTH-1:0]        left_value;
      logic signed [PRIO_WIDTH-1:0] left_prio;
      logic [DATA_WIDTH-1:0]        right_value;
      logic signed [PRIO_WIDTH-1:0] right_prio;

      assign occupied = (CountWidth'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_after = 1'b1;
         assign left_value = req_item_value;
         assign left_prio = req_item_priority;
      end else begin : g_body
         assign left_after = cell_after[i-1];
         assign left_value = cell_value[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[i];
         assign right_prio = cell_prio[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_prio = cell_prio[i+1];
      end

      sspq_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .PRIO_WIDTH(PRIO_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occupied),
         .new_value  (req_item_value),
         .new_prio   (req_item_priority),
         .left_after (left_after),
         .left_value (left_value),
         .left_prio  (left_prio),
         .right_value(right_value),
         .right_prio (right_prio),
         .value      (cell_value[i]),
         .prio       (cell_prio[i]),
         .after      (cell_after[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in = status_ff;
      removed_in = removed_ff;
      count_in = count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         status_in = STATUS_OK;
         removed_in = '0;
         case (req_mode)
            MODE_INSERT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_REMOVE: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  removed_in = cell_value[0];
                  count_in = count_ff - 1'b1;
               end
            end
            MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
      end
      status_ff <= status_in;
      removed_ff <= removed_in;
   end

   // state changes only on accept, so head and count read straight from the row
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_head_value = empty ? '0 : cell_value[0];
   assign rsp_entry_count = count_ff;
   assign rsp_empty_flag = empty;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("entry count above depth");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == MODE_INSERT) && full)
      |=> (rsp_status == STATUS_FULL) && $stable(count_ff))
      else $error("insert into full queue not rejected");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == MODE_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries behind");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CountWidth'(2)) |-> (cell_prio[0] <= cell_prio[1]))
      else $error("head entry out of order");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted item gave no result");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
   import sspq_pkg::*;

   localparam int QDEPTH = DEPTH_DEFAULT;
   localparam int DW = DATA_WIDTH_DEFAULT;
   localparam int PW = PRIO_WIDTH_DEFAULT;
   localparam int CW = $clog2(QDEPTH + 1);
   // the fourth mode code does nothing and only reports the head, count and empty flag
   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int RANDOM_OPS = 625;
   localparam int TAIL_CYCLES = 10;

   typedef struct packed {
      logic [1:0]           mode;
      logic [DW-1:0]        value;
      logic signed [PW-1:0] prio;
      logic                 drain_first;
   } queue_op_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [DW-1:0] removed;
      logic [DW-1:0] head;
      logic [CW-1:0] count;
      logic          empty;
   } queue_reply_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_mode = MODE_INSERT;
   logic [DW-1:0]        req_item_value = '0;
   logic signed [PW-1:0] req_item_priority = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [DW-1:0]        rsp_removed_value;
   logic [DW-1:0]        rsp_head_value;
   logic [CW-1:0]        rsp_entry_count;
   logic                 rsp_empty_flag;

   // shadow copy of the sorted entries, head at index zero
   logic [DW-1:0]        shadow_values [QDEPTH];
   logic signed [PW-1:0] shadow_prios [QDEPTH];
   int                   shadow_count = 0;

   queue_op_type    pending_ops [$];
   queue_reply_type awaited_replies [$];
   queue_op_type    next_op;
   queue_op_type    accepted_op;
   queue_reply_type predicted_reply;
   queue_reply_type oldest_reply;
   logic            item_taken = 1'b0;
   int              sent_count = 0;
   int              total_ops = 0;
   int              mismatch_count = 0;
   int              directed_prios [QDEPTH] = '{0, -32768, 32767, 5, 5, -1, 5, 1,
                                                -32768, 32767, 0, -2, 3, 3, 100, -100};

   stable_sorted_priority_queue_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_head_value    (rsp_head_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_empty_flag    (rsp_empty_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic queue_reply_type apply_to_shadow(queue_op_type op);
      queue_reply_type r;
      int pos;
      int i;
      r = '0;
      r.status = STATUS_OK;
      case (op.mode)
         MODE_INSERT: begin
            if (shadow_count >= QDEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // new entry goes behind every entry of equal or lower priority
               pos = 0;
               while (pos < shadow_count && $signed(shadow_prios[pos]) <= $signed(op.prio))
                  pos++;
               for (i = shadow_count; i > pos; i--) begin
                  shadow_values[i] = shadow_values[i-1];
                  shadow_prios[i] = shadow_prios[i-1];
               end
               shadow_values[pos] = op.value;
               shadow_prios[pos] = op.prio;
               shadow_count++;
            end
         end
         MODE_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.removed = shadow_values[0];
               for (i = 1; i < shadow_count; i++) begin
                  shadow_values[i-1] = shadow_values[i];
                  shadow_prios[i-1] = shadow_prios[i];
               end
               shadow_count--;
            end
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      r.head = (shadow_count > 0) ? shadow_values[0] : '0;
      r.count = CW'(shadow_count);
      r.empty = (shadow_count == 0);
      return r;
   endfunction

   function automatic int sender_gap_pct();
      if (sent_count < total_ops / 3) return 19;
      if (sent_count < 2 * total_ops / 3) return 48;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (sent_count < total_ops / 3) return 48;
      if (sent_count < 2 * total_ops / 3) return 19;
      return 0;
   endfunction

   task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
      mismatch_count++;
      $display("tb: mismatch on %s: got %h, want %h", what, got, want);
   endtask

   task automatic add_op(logic [1:0] mode, logic [DW-1:0] value, logic [PW-1:0] prio,
                         logic drain_first);
      queue_op_type op;
      op.mode = mode;
      op.value = value;
      op.prio = prio;
      op.drain_first = drain_first;
      pending_ops = {pending_ops, op};
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct());
         if (!req_valid || item_taken) begin
            if (pending_ops.size() != 0
                && !(pending_ops[0].drain_first && awaited_replies.size() != 0)
                && $urandom_range(99) >= sender_gap_pct()) begin
               next_op = pending_ops.pop_front();
               req_mode <= next_op.mode;
               req_item_value <= next_op.value;
               req_item_priority <= next_op.prio;
               req_valid <= 1'b1;
               sent_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: results sampled on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("unexpected item", rsp_head_value, '0);
            end else begin
               oldest_reply = awaited_replies.pop_front();
               if (rsp_status !== oldest_reply.status)
                  report_mismatch("status", DW'(rsp_status), DW'(oldest_reply.status));
               if (rsp_removed_value !== oldest_reply.removed)
                  report_mismatch("removed_value", rsp_removed_value, oldest_reply.removed);
               if (rsp_head_value !== oldest_reply.head)
                  report_mismatch("head_value", rsp_head_value, oldest_reply.head);
               if (rsp_entry_count !== oldest_reply.count)
                  report_mismatch("entry_count", DW'(rsp_entry_count),
                                  DW'(oldest_reply.count));
               if (rsp_empty_flag !== oldest_reply.empty)
                  report_mismatch("empty_flag", DW'(rsp_empty_flag), DW'(oldest_reply.empty));
            end
         end
         if (req_valid && req_ready) begin
            accepted_op.mode = req_mode;
            accepted_op.value = req_item_value;
            accepted_op.prio = req_item_priority;
            accepted_op.drain_first = 1'b0;
            predicted_reply = apply_to_shadow(accepted_op);
            awaited_replies = {awaited_replies, predicted_reply};
         end
      end
      item_taken <= !reset && req_valid && req_ready;
   end

   initial begin
      int k;
      int n;
      int pick;
      int fill_bias;
      logic [1:0] mode;
      logic [PW-1:0] prio;

      // directed: empty cases, fill with ties and extremes, full, clear
      add_op(MODE_REMOVE, $urandom, PW'($urandom), 1'b0);
      add_op(MODE_NOP, $urandom, PW'($urandom), 1'b0);
      for (k = 0; k < QDEPTH; k++)
         add_op(MODE_INSERT, (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : 32'hA5A5_0000 | k,
                PW'(directed_prios[k]), 1'b0);
      add_op(MODE_INSERT, 32'h5A5A_5A5A, 16'h8000, 1'b0);
      add_op(MODE_NOP, $urandom, PW'($urandom), 1'b0);
      add_op(MODE_REMOVE, $urandom, PW'($urandom), 1'b0);
      add_op(MODE_REMOVE, $urandom, PW'($urandom), 1'b0);
      add_op(MODE_CLEAR, $urandom, PW'($urandom), 1'b0);
      add_op(MODE_REMOVE, $urandom, PW'($urandom), 1'b0);
      add_op(MODE_CLEAR, $urandom, PW'($urandom), 1'b0);

      // random: runs biased toward filling or draining, many priority ties
      fill_bias = 50;
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) fill_bias = $urandom_range(15, 90);
         pick = $urandom_range(99);
         if (pick < 3) mode = MODE_CLEAR;
         else if (pick < 6) mode = MODE_NOP;
         else if ($urandom_range(99) < fill_bias) mode = MODE_INSERT;
         else mode = MODE_REMOVE;
         if ($urandom_range(1) == 1) prio = PW'($urandom_range(8) - 4);
         else prio = PW'($urandom);
         add_op(mode, $urandom, prio, (n % 150 == 0));
      end
      total_ops = pending_ops.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
